@@ rtl/hvr_pkg.sv @@
// ----------------------------------------------------------------------------
// hvr_pkg
// Shared types, constants and saturating arithmetic for the polynomial
// value and rate pipeline.
// ----------------------------------------------------------------------------
package hvr_pkg;

   localparam int NumCoeffs = 6;
   localparam int DataW     = 64;
   localparam int XW        = 10;
   localparam int CountW    = 3;
   localparam int IdxW      = 3;

   localparam logic [DataW-1:0] DataMax = {1'b0, {(DataW-1){1'b1}}};
   localparam logic [DataW-1:0] DataMin = {1'b1, {(DataW-1){1'b0}}};

   typedef logic [DataW-1:0] data_type;

   typedef struct packed {
      data_type value;
      logic     ovf;
   } sat_type;

   // one evaluation in flight
   typedef struct packed {
      data_type [NumCoeffs-1:0] coef;   // masked by count
      data_type [NumCoeffs-1:1] dcoef;  // coef[k] * k, saturated
      logic [XW-1:0]            x;
      data_type                 y;      // value accumulator
      data_type                 r;      // rate accumulator
      logic                     ovf;
   } item_type;

   // signed 64 x unsigned 10, clamped to 64 bits
   function automatic sat_type sat_mul(data_type a, logic [XW-1:0] b);
      logic signed [DataW+XW:0] wa;
      logic signed [DataW+XW:0] wb;
      logic signed [DataW+XW:0] p;
      sat_type                  s;
      wa = {{(XW+1){a[DataW-1]}}, a};
      wb = {{DataW{1'b0}}, b};
      p  = wa * wb;
      if (p[DataW+XW:DataW-1] == {(XW+2){p[DataW+XW]}}) begin
         s.value = p[DataW-1:0];
         s.ovf   = 1'b0;
      end else begin
         s.value = p[DataW+XW] ? DataMin : DataMax;
         s.ovf   = 1'b1;
      end
      return s;
   endfunction

   function automatic sat_type sat_add(data_type a, data_type b);
      logic signed [DataW:0] t;
      sat_type               s;
      t = $signed({a[DataW-1], a}) + $signed({b[DataW-1], b});
      if (t[DataW] == t[DataW-1]) begin
         s.value = t[DataW-1:0];
         s.ovf   = 1'b0;
      end else begin
         s.value = t[DataW] ? DataMin : DataMax;
         s.ovf   = 1'b1;
      end
      return s;
   endfunction

endpackage

@@ rtl/hvr_if.sv @@
// ----------------------------------------------------------------------------
// hvr_req_if / hvr_rsp_if
// Valid/ready channels for evaluation requests and their results.
// ----------------------------------------------------------------------------
interface hvr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [hvr_pkg::DataW-1:0]              coef_0;
   logic [hvr_pkg::DataW-1:0]              coef_1;
   logic [hvr_pkg::DataW-1:0]              coef_2;
   logic [hvr_pkg::DataW-1:0]              coef_3;
   logic [hvr_pkg::DataW-1:0]              coef_4;
   logic [hvr_pkg::DataW-1:0]              coef_5;
   logic [hvr_pkg::CountW-1:0]             coef_count;
   logic [hvr_pkg::XW-1:0]                 time_offset;

   modport source (output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5,
                   coef_count, time_offset, input ready);
   modport sink   (input valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5,
                   coef_count, time_offset, output ready);
endinterface

interface hvr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [hvr_pkg::DataW-1:0] value;
   logic [hvr_pkg::DataW-1:0] rate;
   logic                      overflow;

   modport source (output valid, value, rate, overflow, input ready);
   modport sink   (input valid, value, rate, overflow, output ready);
endinterface

@@ rtl/poly_value_and_rate_eval_unit.sv @@
// ----------------------------------------------------------------------------
// poly_value_and_rate_eval_unit
// Polynomial value and first derivative at an integer point, Horner's rule,
// signed Q27.36 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries six coefficients, a coefficient count and a time offset; one
//   transaction moves on each edge with valid and ready high. rsp returns value,
//   rate and an overflow flag, one transaction per request, in request order.
//   The datapath is eleven register stages: a setup stage that masks and
//   scales the coefficients, then five multiply/add pairs of the Horner chain.
//   Throughput is one transaction per cycle while rsp stays ready.
//   Each stage holds its item while the next one is full and stalled; empty
//   stages keep filling, so req stays ready until every stage is occupied.
//   A stall never drops or repeats a transaction.
//   Synchronous reset empties all stages; no configuration is needed.
// ----------------------------------------------------------------------------
module poly_value_and_rate_eval_unit (
   input  logic         clock,
   input  logic         reset,
   hvr_req_if.sink      req,
   hvr_rsp_if.source    rsp
);

   localparam int NumSteps  = hvr_pkg::NumCoeffs - 1;
   localparam int NumStages = 2 * NumSteps + 1;

   logic                                       valid [NumStages];
   logic                                       ready [NumStages];
   hvr_pkg::item_type                          item  [NumStages];
   hvr_pkg::data_type [hvr_pkg::NumCoeffs-1:0] req_coef;

   assign req_coef = {req.coef_5, req.coef_4, req.coef_3,
                      req.coef_2, req.coef_1, req.coef_0};

   hvr_pre_stage u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_coef   (req_coef),
      .in_count  (req.coef_count),
      .in_x      (req.time_offset),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_item  (item[0])
   );

   for (genvar g = 0; g < NumSteps; g++) begin : g_step
      hvr_mul_stage u_mul (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (hvr_pkg::IdxW'(NumSteps - 1 - g)),
         .in_valid  (valid[2*g]),
         .in_ready  (ready[2*g]),
         .in_item   (item[2*g]),
         .out_valid (valid[2*g+1]),
         .out_ready (ready[2*g+1]),
         .out_item  (item[2*g+1])
      );

      hvr_add_stage u_add (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (hvr_pkg::IdxW'(NumSteps - 1 - g)),
         .in_valid  (valid[2*g+1]),
         .in_ready  (ready[2*g+1]),
         .in_item   (item[2*g+1]),
         .out_valid (valid[2*g+2]),
         .out_ready (ready[2*g+2]),
         .out_item  (item[2*g+2])
      );
   end

   assign ready[NumStages-1] = rsp.ready;
   assign rsp.valid          = valid[NumStages-1];
   assign rsp.value          = item[NumStages-1].y;
   assign rsp.rate           = item[NumStages-1].r;
   assign rsp.overflow       = item[NumStages-1].ovf;

endmodule

@@ rtl/hvr_pre_stage.sv @@
// ----------------------------------------------------------------------------
// hvr_pre_stage
// Masks coefficients by count, scales them for the derivative and seeds
// both Horner accumulators with the top-order terms.
// ----------------------------------------------------------------------------
module hvr_pre_stage (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  hvr_pkg::data_type [hvr_pkg::NumCoeffs-1:0]  in_coef,
   input  logic [hvr_pkg::CountW-1:0]                  in_count,
   input  logic [hvr_pkg::XW-1:0]                      in_x,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output hvr_pkg::item_type                           out_item
);

   logic              valid_ff;
   hvr_pkg::item_type item_ff;
   hvr_pkg::item_type item_in;

   always_comb begin
      hvr_pkg::sat_type m;
      item_in     = '0;
      item_in.x   = in_x;
      for (int k = 0; k < hvr_pkg::NumCoeffs; k++) begin
         // count of 7 keeps all six, count of 0 keeps none
         item_in.coef[k] = (k < int'(in_count)) ? in_coef[k] : '0;
      end
      for (int k = 1; k < hvr_pkg::NumCoeffs; k++) begin
         m                = hvr_pkg::sat_mul(item_in.coef[k], hvr_pkg::XW'(k));
         item_in.dcoef[k] = m.value;
         item_in.ovf      = item_in.ovf | m.ovf;
      end
      item_in.y = item_in.coef[hvr_pkg::NumCoeffs-1];
      item_in.r = item_in.dcoef[hvr_pkg::NumCoeffs-1];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/hvr_mul_stage.sv @@
// ----------------------------------------------------------------------------
// hvr_mul_stage
// Horner multiply step: value and rate times x; only the value at stage_idx 0.
// ----------------------------------------------------------------------------
module hvr_mul_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [hvr_pkg::IdxW-1:0]   stage_idx,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hvr_pkg::item_type          in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hvr_pkg::item_type          out_item
);

   logic              valid_ff;
   hvr_pkg::item_type item_ff;
   hvr_pkg::item_type item_in;

   always_comb begin
      hvr_pkg::sat_type my;
      hvr_pkg::sat_type mr;
      item_in     = in_item;
      my          = hvr_pkg::sat_mul(in_item.y, in_item.x);
      mr          = hvr_pkg::sat_mul(in_item.r, in_item.x);
      item_in.y   = my.value;
      item_in.ovf = in_item.ovf | my.ovf;
      // rate chain ends one step before the constant term
      if (stage_idx != '0) begin
         item_in.r   = mr.value;
         item_in.ovf = item_in.ovf | mr.ovf;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/hvr_add_stage.sv @@
// ----------------------------------------------------------------------------
// hvr_add_stage
// Horner add step: value += coef k; rate += k*coef k, except at k = 0.
// ----------------------------------------------------------------------------
module hvr_add_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [hvr_pkg::IdxW-1:0]   stage_idx,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hvr_pkg::item_type          in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hvr_pkg::item_type          out_item
);

   logic              valid_ff;
   hvr_pkg::item_type item_ff;
   hvr_pkg::item_type item_in;

   always_comb begin
      hvr_pkg::sat_type ay;
      hvr_pkg::sat_type ar;
      item_in     = in_item;
      ay          = hvr_pkg::sat_add(in_item.y, in_item.coef[stage_idx]);
      ar          = hvr_pkg::sat_add(in_item.r, in_item.dcoef[stage_idx]);
      item_in.y   = ay.value;
      item_in.ovf = in_item.ovf | ay.ovf;
      if (stage_idx != '0) begin
         item_in.r   = ar.value;
         item_in.ovf = item_in.ovf | ar.ovf;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
